// ----- design/msxrng_pkg.sv -----
// ----------------------------------------------------------------------------
// msxrng_pkg
// Types, constants and helper functions shared by the multi-stream
// xorshift32 random number generator.
// ----------------------------------------------------------------------------
`default_nettype none

package msxrng_pkg;

   // Number of generator streams (1 to 16)
   localparam int STREAMS = 8;
   localparam int IDX_W   = (STREAMS > 1) ? $clog2(STREAMS) : 1;

   localparam logic [31:0] GOLDEN_MUL = 32'h9E37_79B9;
   localparam logic [31:0] ZERO_SUB   = 32'hA341_316C;

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;

   // Operation codes
   localparam logic OP_RESEED = 1'b0;
   localparam logic OP_DRAW   = 1'b1;

   // CSR register indexes (word address)
   localparam logic CSR_BASE_SEED = 1'b0;

   typedef struct packed {
      logic       op;
      logic [3:0] stream_index;
   } req_type;

   typedef struct packed {
      logic [31:0] random_value;
      logic        bad_stream;
   } rsp_type;

   // Update request from the datapath to the state table
   typedef struct packed {
      logic             reseed;
      logic             draw_we;
      logic [IDX_W-1:0] index;
      logic [31:0]      value;
   } state_cmd_type;

   function automatic logic [31:0] nonzero(input logic [31:0] v);
      return (v != 32'd0) ? v : ZERO_SUB;
   endfunction

   // Seed mix for stream i: GOLDEN_MUL * (i + 1) mod 2^32 (elaboration time)
   function automatic logic [31:0] stream_mix(input int i);
      logic [63:0] p;
      p = 64'(GOLDEN_MUL) * 64'(i + 1);
      return p[31:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/msxrng_csr.sv -----
// ----------------------------------------------------------------------------
// msxrng_csr
// APB register file: holds the base seed.
// ----------------------------------------------------------------------------
`default_nettype none

module msxrng_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output logic      [31:0] base_seed
);

   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      seed_in = seed_ff;
      if (wr_en && (paddr[2] == msxrng_pkg::CSR_BASE_SEED)) begin
         seed_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         msxrng_pkg::CSR_BASE_SEED: prdata = seed_ff;
         default:                   prdata = 32'd0;
      endcase
   end

   assign base_seed = seed_ff;

endmodule

`default_nettype wire

// ----- design/msxrng_state.sv -----
// ----------------------------------------------------------------------------
// msxrng_state
// Stream state table. A reseed loads every stream at once from the base
// seed; a draw writes back one stream.
// ----------------------------------------------------------------------------
`default_nettype none

module msxrng_state (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire msxrng_pkg::state_cmd_type        cmd,
   input  wire logic [31:0]                      base_seed,
   input  wire logic [msxrng_pkg::IDX_W-1:0]     rd_index,
   output logic      [31:0]                      rd_value
);

   logic [31:0] state_ff [msxrng_pkg::STREAMS];
   logic [31:0] state_in [msxrng_pkg::STREAMS];

   always_comb begin
      for (int i = 0; i < msxrng_pkg::STREAMS; i++) begin
         state_in[i] = state_ff[i];
         if (cmd.reseed) begin
            state_in[i] = msxrng_pkg::nonzero(base_seed ^ msxrng_pkg::stream_mix(i));
         end else if (cmd.draw_we && (cmd.index == msxrng_pkg::IDX_W'(i))) begin
            state_in[i] = cmd.value;
         end
      end
   end

   // reset state is the reseed with a zero base seed
   always_ff @(posedge clock) begin
      for (int i = 0; i < msxrng_pkg::STREAMS; i++) begin
         if (reset) begin
            state_ff[i] <= msxrng_pkg::nonzero(msxrng_pkg::stream_mix(i));
         end else begin
            state_ff[i] <= state_in[i];
         end
      end
   end

   always_comb begin
      rd_value = 32'd0;
      for (int i = 0; i < msxrng_pkg::STREAMS; i++) begin
         if (rd_index == msxrng_pkg::IDX_W'(i)) begin
            rd_value = state_ff[i];
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/msxrng_step.sv -----
// ----------------------------------------------------------------------------
// msxrng_step
// One xorshift32 step (13/17/5) with zero-state substitution.
// ----------------------------------------------------------------------------
`default_nettype none

module msxrng_step (
   input  wire logic [31:0] cur_value,
   output logic      [31:0] next_value
);

   logic [31:0] s1;
   logic [31:0] s2;
   logic [31:0] s3;

   assign s1 = cur_value ^ (cur_value << msxrng_pkg::SHIFT_A);
   assign s2 = s1 ^ (s1 >> msxrng_pkg::SHIFT_B);
   assign s3 = s2 ^ (s2 << msxrng_pkg::SHIFT_C);

   assign next_value = msxrng_pkg::nonzero(s3);

endmodule

`default_nettype wire

// ----- design/multi_stream_xorshift32_rng.sv -----
// ----------------------------------------------------------------------------
// multi_stream_xorshift32_rng
// Table of independent xorshift32 streams with reseed and draw commands.
//
//   channel   ports                               direction  handshake
//   request   start, busy, req_data               in         start & !busy
//   result    rsp_valid, rsp_data                 out        one-cycle strobe
//   csr       psel penable pwrite paddr pwdata    in/out     APB, pready = 1
//             prdata pready
//
// One word accepted per cycle; busy stays low. A command is captured in the
// request register; the state table read, one xorshift step and write-back
// complete as the result register loads, so a draw strobes once the request
// and then the result register have loaded. Reseed updates every stream as
// the result register loads and gives no result. The receiver cannot stall.
// Synchronous reset loads the streams as if reseeded with a zero seed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stream_xorshift32_rng (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire msxrng_pkg::req_type  req_data,
   output logic                      rsp_valid,
   output msxrng_pkg::rsp_type       rsp_data,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready
);

   logic                      item_valid_ff;
   msxrng_pkg::req_type       item_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   msxrng_pkg::rsp_type       rsp_data_ff;
   msxrng_pkg::rsp_type       rsp_data_in;

   logic [31:0]               base_seed;
   logic [31:0]               cur_value;
   logic [31:0]               next_value;
   logic                      bad;
   logic                      is_draw;
   msxrng_pkg::state_cmd_type cmd;

   assign busy = 1'b0;

   msxrng_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .base_seed (base_seed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= start & ~busy;
      end
      item_ff <= req_data;
   end

   assign bad     = ({1'b0, item_ff.stream_index} >= 5'(msxrng_pkg::STREAMS));
   assign is_draw = item_valid_ff && (item_ff.op == msxrng_pkg::OP_DRAW);

   assign cmd.reseed  = item_valid_ff && (item_ff.op == msxrng_pkg::OP_RESEED);
   assign cmd.draw_we = is_draw && !bad;
   assign cmd.index   = item_ff.stream_index[msxrng_pkg::IDX_W-1:0];
   assign cmd.value   = next_value;

   msxrng_state u_state (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .base_seed (base_seed),
      .rd_index  (item_ff.stream_index[msxrng_pkg::IDX_W-1:0]),
      .rd_value  (cur_value)
   );

   msxrng_step u_step (
      .cur_value  (cur_value),
      .next_value (next_value)
   );

   always_comb begin
      rsp_valid_in             = is_draw;
      rsp_data_in.random_value = bad ? 32'd0 : next_value;
      rsp_data_in.bad_stream   = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
